FILE: src/voronoi_nearest_seed_region_average_unit_assert.svh
// assertion macros for the voronoi nearest seed region average unit
// expects clk_i and rst_ni in the scope of each use
`ifndef VORONOI_NEAREST_SEED_REGION_AVERAGE_UNIT_ASSERT_SVH
`define VORONOI_NEAREST_SEED_REGION_AVERAGE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define VNSA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define VNSA_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);
`else
`define VNSA_ASSERT(label, prop, msg)
`define VNSA_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

FILE: src/vnsa_pkg.sv
// shared types and constants of the voronoi nearest seed region average unit
// no dependencies
package vnsa_pkg;

  localparam int MaxSeeds  = 1024;
  localparam int CoordBits = 12;
  localparam int CountBits = 24;
  localparam int SumBits   = 32;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_ACCUM = 2'd1;
  localparam logic [1:0] ACT_EMIT  = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  localparam logic [1:0] MET_EUCLID = 2'd0;
  localparam logic [1:0] MET_MANH   = 2'd1;
  localparam logic [1:0] MET_CHEB   = 2'd2;

  localparam logic CFG_METRIC     = 1'b0;
  localparam logic CFG_SEED_COUNT = 1'b1;

  typedef struct packed {
    logic capture;
    logic seed_wr;
    logic scan_start;
    logic clr_start;
    logic sum_rd;
    logic sum_acc;
    logic div_start;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic       scan_done;
    logic       clr_done;
    logic       div_done;
    logic [1:0] action;
  } status_t;

endpackage

FILE: src/vnsa_div.sv
// restoring divider for one color channel with round half to even and saturation
// depends on vnsa_pkg
module vnsa_div #(
  parameter int COUNT_BITS = vnsa_pkg::CountBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [vnsa_pkg::SumBits-1:0]   sum_i,
  input  logic [COUNT_BITS-1:0]          count_i,
  output logic                           done_o,
  output logic [7:0]                     mean_o
);

  localparam int SW = vnsa_pkg::SumBits;
  localparam int CW = $clog2(SW);

  logic                  run_q, run_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [SW-1:0]         dvd_q, dvd_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [COUNT_BITS-1:0] den_q, den_d;
  logic [COUNT_BITS:0]   rem_sh;
  logic                  ge;
  logic [COUNT_BITS:0]   two_r;
  logic                  rnd;
  logic [SW:0]           q_rnd;

  always_comb begin
    rem_sh = {rem_q, dvd_q[SW-1]};
    ge     = rem_sh >= {1'b0, den_q};
    run_d  = run_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      dvd_d = sum_i;
      rem_d = '0;
      den_d = count_i;
    end else if (run_q) begin
      rem_d = ge ? COUNT_BITS'(rem_sh - {1'b0, den_q}) : COUNT_BITS'(rem_sh);
      dvd_d = {dvd_q[SW-2:0], ge};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(SW - 1)) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  always_comb begin
    two_r = {rem_q, 1'b0};
    rnd   = (two_r > {1'b0, den_q}) || ((two_r == {1'b0, den_q}) && dvd_q[0]);
    q_rnd = {1'b0, dvd_q} + (SW + 1)'(rnd);
    if (den_q == '0) begin
      mean_o = '0;
    end else if (q_rnd > (SW + 1)'(255)) begin
      mean_o = 8'hff;
    end else begin
      mean_o = q_rnd[7:0];
    end
  end

  assign done_o = !run_q;

endmodule

FILE: src/vnsa_datapath.sv
// datapath: seed table, distance scan pipeline, region sums memory, dividers, result regs
// depends on vnsa_pkg and vnsa_div
module vnsa_datapath #(
  parameter int MAX_SEEDS  = vnsa_pkg::MaxSeeds,
  parameter int COORD_BITS = vnsa_pkg::CoordBits,
  parameter int COUNT_BITS = vnsa_pkg::CountBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vnsa_pkg::cmd_t      cmd_i,
  output vnsa_pkg::status_t   sts_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [10:0]         cfg_wdata_i,
  input  logic [1:0]          action_i,
  input  logic [9:0]          seed_slot_i,
  input  logic [11:0]         pos_x_i,
  input  logic [11:0]         pos_y_i,
  input  logic [7:0]          chan0_i,
  input  logic [7:0]          chan1_i,
  input  logic [7:0]          chan2_i,
  output logic [9:0]          nearest_seed_o,
  output logic [7:0]          diagram_c0_o,
  output logic [7:0]          diagram_c1_o,
  output logic [7:0]          mean_c0_o,
  output logic [7:0]          mean_c1_o,
  output logic [7:0]          mean_c2_o
);

  localparam int SEED_W = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int NW     = SEED_W + 1;
  localparam int CB     = COORD_BITS;
  localparam int DW     = 2 * CB + 1;
  localparam int SW     = vnsa_pkg::SumBits;
  localparam int RW     = 3 * SW + COUNT_BITS;

  // configuration
  logic [1:0]  metric_q;
  logic [10:0] seed_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q     <= vnsa_pkg::MET_EUCLID;
      seed_count_q <= 11'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vnsa_pkg::CFG_METRIC:     metric_q     <= cfg_wdata_i[1:0];
        vnsa_pkg::CFG_SEED_COUNT: seed_count_q <= cfg_wdata_i;
        default:                  metric_q     <= metric_q;
      endcase
    end
  end

  // captured transaction
  logic [1:0]    act_q;
  logic [9:0]    slot_q;
  logic [CB-1:0] px_q, py_q;
  logic [7:0]    c0_q, c1_q, c2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q  <= action_i;
      slot_q <= seed_slot_i;
      px_q   <= CB'(pos_x_i);
      py_q   <= CB'(pos_y_i);
      c0_q   <= chan0_i;
      c1_q   <= chan1_i;
      c2_q   <= chan2_i;
    end
  end

  // seed table
  logic [2*CB-1:0] seed_mem [MAX_SEEDS];
  logic [2*CB-1:0] seed_rd_q;
  logic            slot_ok;
  logic [NW-1:0]   iss_q, n_q, n_eff;
  logic            scan_run_q;
  logic            issue;

  assign slot_ok = 32'(slot_q) < 32'(MAX_SEEDS);
  assign issue   = scan_run_q && (iss_q < n_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.seed_wr && slot_ok) begin
      seed_mem[SEED_W'(slot_q)] <= {py_q, px_q};
    end
    if (issue) begin
      seed_rd_q <= seed_mem[iss_q[SEED_W-1:0]];
    end
  end

  always_comb begin
    if (seed_count_q == 11'd0) begin
      n_eff = NW'(1);
    end else if (32'(seed_count_q) > 32'(MAX_SEEDS)) begin
      n_eff = NW'(MAX_SEEDS);
    end else begin
      n_eff = NW'(seed_count_q);
    end
  end

  // scan pipeline
  logic              v1_q, v2_q;
  logic [SEED_W-1:0] i1_q, i2_q;
  logic [CB-1:0]     x2_q, y2_q;
  logic [2*CB-1:0]   sqx_q, sqy_q;
  logic [CB:0]       lin_q;
  logic [CB-1:0]     rx, ry, dx, dy;
  logic [DW-1:0]     d3;
  logic [DW-1:0]     best_d_q;
  logic [SEED_W-1:0] best_i_q;
  logic [CB-1:0]     best_x_q, best_y_q;

  always_comb begin
    rx = seed_rd_q[CB-1:0];
    ry = seed_rd_q[2*CB-1:CB];
    dx = (rx > px_q) ? rx - px_q : px_q - rx;
    dy = (ry > py_q) ? ry - py_q : py_q - ry;
    if (metric_q == vnsa_pkg::MET_MANH || metric_q == vnsa_pkg::MET_CHEB) begin
      d3 = DW'(lin_q);
    end else begin
      d3 = DW'(sqx_q) + DW'(sqy_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_run_q <= 1'b0;
      iss_q      <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      if (cmd_i.scan_start) begin
        scan_run_q <= 1'b1;
        iss_q      <= '0;
      end else if (issue) begin
        iss_q <= iss_q + NW'(1);
      end else if (sts_o.scan_done) begin
        scan_run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      n_q <= n_eff;
    end
    i1_q  <= iss_q[SEED_W-1:0];
    i2_q  <= i1_q;
    x2_q  <= rx;
    y2_q  <= ry;
    sqx_q <= dx * dx;
    sqy_q <= dy * dy;
    if (metric_q == vnsa_pkg::MET_MANH) begin
      lin_q <= {1'b0, dx} + {1'b0, dy};
    end else begin
      lin_q <= (dx > dy) ? {1'b0, dx} : {1'b0, dy};
    end
    if (v2_q && ((i2_q == '0) || (d3 < best_d_q))) begin
      best_d_q <= d3;
      best_i_q <= i2_q;
      best_x_q <= x2_q;
      best_y_q <= y2_q;
    end
  end

  // region sums memory: {sum0, sum1, sum2, count}
  logic [RW-1:0]         sum_mem [MAX_SEEDS];
  logic [RW-1:0]         sum_rd_q;
  logic                  clr_run_q;
  logic [SEED_W-1:0]     clr_idx_q;
  logic [SW-1:0]         s0, s1, s2;
  logic [COUNT_BITS-1:0] cnt;
  logic [SW:0]           a0, a1, a2;
  logic                  cnt_full;

  always_comb begin
    s0       = sum_rd_q[RW-1 -: SW];
    s1       = sum_rd_q[RW-SW-1 -: SW];
    s2       = sum_rd_q[RW-2*SW-1 -: SW];
    cnt      = sum_rd_q[COUNT_BITS-1:0];
    a0       = {1'b0, s0} + (SW + 1)'(c0_q);
    a1       = {1'b0, s1} + (SW + 1)'(c1_q);
    a2       = {1'b0, s2} + (SW + 1)'(c2_q);
    cnt_full = &cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_run_q <= 1'b1;
      clr_idx_q <= '0;
    end else if (cmd_i.clr_start) begin
      clr_run_q <= 1'b1;
      clr_idx_q <= '0;
    end else if (clr_run_q) begin
      clr_idx_q <= clr_idx_q + SEED_W'(1);
      if (sts_o.clr_done) begin
        clr_run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_run_q) begin
      sum_mem[clr_idx_q] <= '0;
    end else if (cmd_i.sum_acc && !cnt_full) begin
      sum_mem[best_i_q] <= {a0[SW] ? {SW{1'b1}} : a0[SW-1:0],
                            a1[SW] ? {SW{1'b1}} : a1[SW-1:0],
                            a2[SW] ? {SW{1'b1}} : a2[SW-1:0],
                            cnt + COUNT_BITS'(1)};
    end
    if (cmd_i.sum_rd) begin
      sum_rd_q <= sum_mem[best_i_q];
    end
  end

  // dividers
  logic       dd0, dd1, dd2;
  logic [7:0] m0, m1, m2;

  vnsa_div #(.COUNT_BITS(COUNT_BITS)) u_div0 (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .sum_i(s0), .count_i(cnt),
    .done_o(dd0), .mean_o(m0)
  );
  vnsa_div #(.COUNT_BITS(COUNT_BITS)) u_div1 (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .sum_i(s1), .count_i(cnt),
    .done_o(dd1), .mean_o(m1)
  );
  vnsa_div #(.COUNT_BITS(COUNT_BITS)) u_div2 (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .sum_i(s2), .count_i(cnt),
    .done_o(dd2), .mean_o(m2)
  );

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      if (act_q == vnsa_pkg::ACT_LOAD || act_q == vnsa_pkg::ACT_CLEAR) begin
        nearest_seed_o <= '0;
        diagram_c0_o   <= '0;
        diagram_c1_o   <= '0;
      end else begin
        nearest_seed_o <= 10'(best_i_q);
        diagram_c0_o   <= 8'(best_y_q);
        diagram_c1_o   <= 8'(best_x_q);
      end
      if (act_q == vnsa_pkg::ACT_EMIT) begin
        mean_c0_o <= m0;
        mean_c1_o <= m1;
        mean_c2_o <= m2;
      end else begin
        mean_c0_o <= '0;
        mean_c1_o <= '0;
        mean_c2_o <= '0;
      end
    end
  end

  assign sts_o.scan_done = scan_run_q && (iss_q == n_q) && !v1_q && !v2_q;
  assign sts_o.clr_done  = clr_run_q && (clr_idx_q == SEED_W'(MAX_SEEDS - 1));
  assign sts_o.div_done  = dd0 && dd1 && dd2;
  assign sts_o.action    = act_q;

endmodule

FILE: src/vnsa_ctrl.sv
// controller state machine sequencing clear, scan, sum update, divide and output
// depends on vnsa_pkg
module vnsa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        action_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  vnsa_pkg::status_t sts_i,
  output vnsa_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLEAR  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_SUMRD  = 3'd3;
  localparam logic [2:0] S_SUMUSE = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state_q, state_d;
  logic       item_q, item_d;
  logic       ovalid_q, ovalid_d;
  logic       accept;

  assign in_stall_o  = state_q != S_IDLE;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    item_d   = item_q;
    ovalid_d = ovalid_q && out_stall_i;
    cmd_o    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          item_d        = 1'b1;
          unique case (action_i)
            vnsa_pkg::ACT_LOAD: state_d = S_FINISH;
            vnsa_pkg::ACT_CLEAR: begin
              cmd_o.clr_start = 1'b1;
              state_d         = S_CLEAR;
            end
            default: begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end
          endcase
        end
      end
      S_CLEAR: begin
        if (sts_i.clr_done) begin
          state_d = item_q ? S_FINISH : S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = S_SUMRD;
        end
      end
      S_SUMRD: begin
        cmd_o.sum_rd = 1'b1;
        state_d      = S_SUMUSE;
      end
      S_SUMUSE: begin
        if (sts_i.action == vnsa_pkg::ACT_ACCUM) begin
          cmd_o.sum_acc = 1'b1;
          state_d       = S_FINISH;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.seed_wr = sts_i.action == vnsa_pkg::ACT_LOAD;
        if (!ovalid_q || !out_stall_i) begin
          cmd_o.res_load = 1'b1;
          ovalid_d       = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      item_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      item_q   <= item_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

FILE: src/voronoi_nearest_seed_region_average_unit.sv
// top level of the voronoi nearest seed region average unit
// depends on vnsa_pkg, vnsa_ctrl, vnsa_datapath and the assertion macro header
//
// Input channel: in_valid_i / in_stall_o with action, seed slot, position and
// three color channels. Output channel: out_valid_o / out_stall_i, one result
// transaction for every input transaction, in order.
// Configuration: cfg_we_i writes metric (index 0) or seed count (index 1);
// the user must write only while no transaction is in flight; not enforced.
// One transaction at a time. Accumulate and emit scan the n seeds in use, and
// clear sweeps all MAX_SEEDS entries of the region sums; the scan reads one
// seed per cycle from the single read port of the seed table, and emit adds
// a 32-step divider.
// After reset the region sums are swept to zero, one entry per cycle;
// in_stall_o is high meanwhile. Configuration writes are taken during
// the sweep.
// The result sits in an output register; while out_stall_i is high it holds,
// a new transaction is still accepted and worked on, and only its final
// handoff waits for the register to free.
`include "voronoi_nearest_seed_region_average_unit_assert.svh"
module voronoi_nearest_seed_region_average_unit #(
  parameter int MAX_SEEDS  = vnsa_pkg::MaxSeeds,
  parameter int COORD_BITS = vnsa_pkg::CoordBits,
  parameter int COUNT_BITS = vnsa_pkg::CountBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [9:0]  seed_slot_i,
  input  logic [11:0] pos_x_i,
  input  logic [11:0] pos_y_i,
  input  logic [7:0]  chan0_i,
  input  logic [7:0]  chan1_i,
  input  logic [7:0]  chan2_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [9:0]  nearest_seed_o,
  output logic [7:0]  diagram_c0_o,
  output logic [7:0]  diagram_c1_o,
  output logic [7:0]  mean_c0_o,
  output logic [7:0]  mean_c1_o,
  output logic [7:0]  mean_c2_o
);

  vnsa_pkg::cmd_t    cmd;
  vnsa_pkg::status_t sts;
  logic              in_accept;
  logic [3:0]        starts;

  vnsa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i,
    .out_valid_o, .out_stall_i, .sts_i(sts), .cmd_o(cmd)
  );

  vnsa_datapath #(
    .MAX_SEEDS(MAX_SEEDS), .COORD_BITS(COORD_BITS), .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .action_i, .seed_slot_i, .pos_x_i, .pos_y_i, .chan0_i, .chan1_i, .chan2_i,
    .nearest_seed_o, .diagram_c0_o, .diagram_c1_o,
    .mean_c0_o, .mean_c1_o, .mean_c2_o
  );

  assign in_accept = in_valid_i && !in_stall_o;
  assign starts    = {cmd.seed_wr, cmd.scan_start, cmd.clr_start, cmd.div_start};

  `VNSA_ASSERT_NEXT(a_busy_after_accept, in_accept, in_stall_o, "accept did not go busy")
  `VNSA_ASSERT(a_one_start, $onehot0(starts), "overlapping starts")
  `VNSA_ASSERT(a_load_busy, !cmd.res_load || in_stall_o, "result loaded while idle")

endmodule
